@@ rtl/assert_macros.svh @@
// Assertion macros used by the back end (smh_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/smh_pkg.sv @@
// Shared types and constants of the stream word mix hash.
package smh_pkg;

	localparam int LANES       = 4;
	localparam int BUF_DEPTH   = LANES - 1;
	localparam int LENGTH_BITS = 32;
	localparam int MIX_SHIFT   = 13;

	localparam logic [63:0] SEED_ACC  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SEED_FEED = 64'hC6A4_A793_5BD1_E995;
	// FNV prime 0x100000001B3 split into 2^40 plus a small factor
	localparam int          PRIME_HIGH_SHIFT = 40;
	localparam logic [8:0]  PRIME_LOW        = 9'h1B3;

	localparam logic [3:0]  FULL_BYTES = 4'd8;

	// One classified word as it travels from the front to the back
	typedef struct packed {
		logic [63:0]            word;
		logic [3:0]             nbytes;
		logic                   full;
		logic                   last;
		logic [LENGTH_BITS-1:0] length;
	} entry_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		S_RUN  = 2'b01,
		S_FOLD = 2'b10
	} back_state_t;

	// Rotate a word left by the mix distance
	function automatic logic [63:0] rotl_mix(input logic [63:0] v);
		rotl_mix = (v << MIX_SHIFT) | (v >> (64 - MIX_SHIFT));
	endfunction

endpackage

@@ rtl/smh_if.sv @@
// Stream channel interfaces of the stream word mix hash.
interface smh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        last_word;

	modport source (output valid, data_word, valid_bytes, last_word, input ready);
	modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface smh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_low_word;
	logic [63:0] hash_high_word;
	logic [31:0] message_length;

	modport source (output valid, hash_low_word, hash_high_word, message_length,
		input ready);
	modport sink (input valid, hash_low_word, hash_high_word, message_length,
		output ready);
endinterface

@@ rtl/smh_front.sv @@
// Front end: classifies incoming words and tracks the message length.
module smh_front
	import smh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	smh_in_if.sink     in_ch,
	input  logic       q_full,
	output logic       push,
	output entry_t     push_entry
);

	logic [LENGTH_BITS-1:0] total_q;
	logic [LENGTH_BITS:0]   sum;
	logic [LENGTH_BITS-1:0] total_n;
	logic [3:0]             n_eff;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && in_ch.ready;

	// Clamp byte count: non-last words and oversize counts are full words
	always_comb begin
		if (!in_ch.last_word || in_ch.valid_bytes > FULL_BYTES) begin
			n_eff = FULL_BYTES;
		end else begin
			n_eff = in_ch.valid_bytes;
		end
	end

	// Saturating length add
	assign sum     = {1'b0, total_q} + (LENGTH_BITS+1)'(n_eff);
	assign total_n = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];

	always_comb begin
		push_entry.word   = in_ch.data_word;
		push_entry.nbytes = n_eff;
		push_entry.full   = (n_eff == FULL_BYTES);
		push_entry.last   = in_ch.last_word;
		push_entry.length = total_n;
	end

	// Advance length, drop it at message end or mode change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_wr_en) begin
			total_q <= '0;
		end else if (push) begin
			total_q <= in_ch.last_word ? '0 : total_n;
		end
	end

endmodule

@@ rtl/smh_queue.sv @@
// Two-entry queue between the front and back ends.
module smh_queue
	import smh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	output logic   q_valid,
	output entry_t q_entry,
	input  logic   pop
);

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_entry = mem_q[rd_ptr_q];

	// Store payload on transfer in
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/smh_back.sv @@
// Back end: word mixing, chunk buffering, tail folding and result register.
`include "assert_macros.svh"
module smh_back
	import smh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_wr_en,
	input  logic   cfg_wr_data,
	input  logic   q_valid,
	input  entry_t q_entry,
	output logic   pop,
	smh_out_if.source out_ch
);

	back_state_t state_q;
	logic        mode_q;

	logic [63:0] acc_q  [LANES];
	logic [63:0] feed_q [LANES];
	logic [63:0] first_q;
	logic [63:0] second_q;
	logic [63:0] buf_q  [BUF_DEPTH];
	logic [1:0]  cnt_q;

	logic [63:0] acc_n  [LANES];
	logic [63:0] feed_n [LANES];
	logic [63:0] wsel   [LANES];
	logic [63:0] first_n;
	logic [63:0] second_n;
	logic [1:0]  cnt_n;
	logic        buf_wr;

	logic [63:0]            hlow_q;
	logic [63:0]            hhigh_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [63:0]            tail_word_q;
	logic [1:0]             tail_cnt_q;
	logic [4:0]             fold_len_q;
	logic [4:0]             idx_q;

	logic [63:0] fold_src;
	logic [7:0]  fold_byte;
	logic [63:0] fold_x;
	logic [63:0] fold_h;
	logic        fold_done;
	logic        emit;

	logic        out_valid_q;
	logic [63:0] out_low_q;
	logic [63:0] out_high_q;
	logic [31:0] out_len_q;

	assign pop       = (state_q == S_RUN) && q_valid;
	assign fold_done = (idx_q == fold_len_q);
	assign emit      = (state_q == S_FOLD) && fold_done && (!out_valid_q || out_ch.ready);

	// Mix the popped word into the scalar sums or the vector lanes
	always_comb begin
		for (int j = 0; j < BUF_DEPTH; j++) begin
			wsel[j] = buf_q[j];
		end
		wsel[LANES-1] = q_entry.word;
		for (int j = 0; j < LANES; j++) begin
			acc_n[j]  = acc_q[j];
			feed_n[j] = feed_q[j];
		end
		first_n  = first_q;
		second_n = second_q;
		cnt_n    = cnt_q;
		buf_wr   = 1'b0;
		if (pop && q_entry.full) begin
			if (mode_q) begin
				if (cnt_q == 2'(BUF_DEPTH)) begin
					for (int j = 0; j < LANES; j++) begin
						acc_n[j]  = (acc_q[j] ^ wsel[j]) + feed_q[j];
						feed_n[j] = acc_n[j] << MIX_SHIFT;
					end
					cnt_n = 2'd0;
				end else begin
					buf_wr = 1'b1;
					cnt_n  = cnt_q + 2'd1;
				end
			end else begin
				first_n  = rotl_mix(first_q ^ q_entry.word);
				second_n = second_q + first_n;
			end
		end
	end

	// Select the next tail byte: buffered words first, then the partial word
	always_comb begin
		case (idx_q[4:3])
			2'd0:    fold_src = buf_q[0];
			2'd1:    fold_src = buf_q[1];
			2'd2:    fold_src = buf_q[2];
			default: fold_src = tail_word_q;
		endcase
		if (idx_q[4:3] == tail_cnt_q) begin
			fold_src = tail_word_q;
		end
		fold_byte = fold_src[{idx_q[2:0], 3'b000} +: 8];
		fold_x    = hlow_q ^ {56'd0, fold_byte};
		fold_h    = (fold_x << PRIME_HIGH_SHIFT) + 64'(fold_x * PRIME_LOW);
	end

	// Hold buffered words until their chunk completes
	always_ff @(posedge clk) begin
		if (buf_wr) begin
			buf_q[cnt_q] <= q_entry.word;
		end
	end

	// Tail fold datapath
	always_ff @(posedge clk) begin
		if (pop && q_entry.last) begin
			hlow_q      <= mode_q ? (acc_n[0] ^ acc_n[1]) : first_n;
			hhigh_q     <= mode_q ? (acc_n[2] ^ acc_n[3]) : second_n;
			len_q       <= q_entry.length;
			tail_word_q <= q_entry.word;
			tail_cnt_q  <= cnt_n;
			fold_len_q  <= {cnt_n, 3'b000} + (q_entry.full ? 5'd0 : {2'b00, q_entry.nbytes[2:0]});
		end else if (state_q == S_FOLD && !fold_done) begin
			hlow_q <= fold_h;
		end
	end

	// Mixing state, sequencer and mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RUN;
			mode_q   <= 1'b0;
			cnt_q    <= 2'd0;
			idx_q    <= 5'd0;
			first_q  <= SEED_ACC;
			second_q <= SEED_FEED;
			for (int j = 0; j < LANES; j++) begin
				acc_q[j]  <= SEED_ACC;
				feed_q[j] <= SEED_FEED;
			end
		end else if (cfg_wr_en) begin
			state_q  <= S_RUN;
			mode_q   <= cfg_wr_data;
			cnt_q    <= 2'd0;
			first_q  <= SEED_ACC;
			second_q <= SEED_FEED;
			for (int j = 0; j < LANES; j++) begin
				acc_q[j]  <= SEED_ACC;
				feed_q[j] <= SEED_FEED;
			end
		end else begin
			case (state_q)
				S_RUN: begin
					if (pop && q_entry.last) begin
						state_q  <= S_FOLD;
						idx_q    <= 5'd0;
						cnt_q    <= 2'd0;
						first_q  <= SEED_ACC;
						second_q <= SEED_FEED;
						for (int j = 0; j < LANES; j++) begin
							acc_q[j]  <= SEED_ACC;
							feed_q[j] <= SEED_FEED;
						end
					end else begin
						cnt_q    <= cnt_n;
						first_q  <= first_n;
						second_q <= second_n;
						for (int j = 0; j < LANES; j++) begin
							acc_q[j]  <= acc_n[j];
							feed_q[j] <= feed_n[j];
						end
					end
				end
				S_FOLD: begin
					if (!fold_done) begin
						idx_q <= idx_q + 5'd1;
					end else if (emit) begin
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	// Result register: load on emit, drop on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_low_q  <= hlow_q;
			out_high_q <= hhigh_q;
			out_len_q  <= 32'(len_q);
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.hash_low_word  = out_low_q;
	assign out_ch.hash_high_word = out_high_q;
	assign out_ch.message_length = out_len_q;

	`ASSERT_IMPLY(a_scalar_no_buf, clk, arst_n, !mode_q, cnt_q == 2'd0, "buffer used in scalar mode")
	`ASSERT_IMPLY(a_fold_bound, clk, arst_n, state_q == S_FOLD, idx_q <= fold_len_q, "fold index past tail")
	`ASSERT_NEXT(a_fold_step, clk, arst_n, state_q == S_FOLD && !fold_done && !cfg_wr_en, state_q == S_FOLD && idx_q == $past(idx_q) + 5'd1, "fold stalled")
	`ASSERT_IMPLY(a_no_pop_in_fold, clk, arst_n, state_q == S_FOLD, !pop, "queue popped while folding")

endmodule

@@ rtl/stream_word_mix_hash.sv @@
// A last word goes through the queue and the fold sequencer to the result register;
// the sequencer folds its F tail bytes (F is 0 to 31), one per cycle.
// The block takes one non-last word per cycle while the queue is not full; the back end
// pops no word while folding and handles one message end at a time.
// Reset (arst_n low): scalar mode, seeds loaded, queue and result register empty.
module stream_word_mix_hash
	import smh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	smh_in_if.sink     in_ch,
	smh_out_if.source  out_ch
);

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   q_valid;
	entry_t q_entry;
	logic   pop;

	// Accept and classify words
	smh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple front from back
	smh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.pop        (pop)
	);

	// Mix, fold and emit results
	smh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule
